// File: rtl/core/fbsdp_pkg.sv
package fbsdp_pkg;

  localparam int LANES   = 8;
  localparam int LIDX_W  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;

  localparam logic [1:0] K_FIN = 2'd0;
  localparam logic [1:0] K_INF = 2'd1;
  localparam logic [1:0] K_NAN = 2'd2;

  typedef struct packed {
    logic               sign;
    logic [1:0]         kind;
    logic [23:0]        sig;
    logic signed [11:0] exp;
  } fnum_t;

  // Weighted-and-scaled element waiting for the accumulator
  typedef struct packed {
    logic [31:0] ws;
    logic [31:0] act;
    logic        last;
  } fe_item_t;

  function automatic fnum_t unpack(input logic [31:0] b);
    fnum_t r;
    r.sign = b[31];
    r.kind = K_FIN;
    r.sig  = '0;
    r.exp  = '0;
    if (b[30:23] == 8'hFF) begin
      r.kind = (b[22:0] != '0) ? K_NAN : K_INF;
    end else if (b[30:23] == 8'h00) begin
      r.sig = {1'b0, b[22:0]};
      r.exp = -12'sd149;
    end else begin
      r.sig = {1'b1, b[22:0]};
      r.exp = $signed({4'b0, b[30:23]}) - 12'sd150;
    end
    return r;
  endfunction

  function automatic logic [5:0] msb64(input logic [63:0] x);
    logic [5:0] k;
    k = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) k = 6'(i);
    end
    return k;
  endfunction

  // Exact e4m3fn decode to FP32 bits
  function automatic logic [31:0] e4m3_bits(input logic [7:0] v);
    logic [31:0] r;
    logic [3:0]  e;
    logic [2:0]  man;
    e   = v[6:3];
    man = v[2:0];
    if (e == 4'd0) begin
      if (man == 3'd0) r = {v[7], 31'b0};
      else if (man[2]) r = {v[7], 8'd120, man[1:0], 21'b0};
      else if (man[1]) r = {v[7], 8'd119, man[0], 22'b0};
      else             r = {v[7], 8'd118, 23'b0};
    end else if (e == 4'hF && man == 3'h7) begin
      r = QNAN_BITS;
    end else begin
      r = {v[7], 8'(e) + 8'd120, man, 20'b0};
    end
    return r;
  endfunction

  // Round sign * sig * 2^exp to FP32, nearest-even, subnormals kept
  function automatic logic [31:0] round_pack(input logic sign, input logic [63:0] sig,
                                             input logic signed [11:0] exp);
    int          shift;
    int          biased;
    logic [63:0] m;
    logic [63:0] rem;
    logic [63:0] half;
    logic        up;
    logic [31:0] r;
    shift = int'(msb64(sig)) - 23;
    if (-149 - int'(exp) > shift) shift = -149 - int'(exp);
    up   = 1'b0;
    m    = '0;
    rem  = '0;
    half = '0;
    if (sig == '0) begin
      r = {sign, 31'b0};
    end else begin
      if (shift <= 0) begin
        m = sig << (-shift);
      end else if (shift >= 64) begin
        up = (shift == 64) && (sig > 64'h8000_0000_0000_0000);
      end else begin
        rem  = sig & ((64'd1 << shift) - 64'd1);
        half = 64'd1 << (shift - 1);
        m    = sig >> shift;
        up   = (rem > half) || (rem == half && m[0]);
      end
      if (up) m = m + 64'd1;
      if (m == (64'd1 << 24)) begin
        m = m >> 1;
        shift = shift + 1;
      end
      if (m >= (64'd1 << 23)) begin
        biased = shift + int'(exp) + 150;
        if (biased >= 255) r = {sign, 8'hFF, 23'b0};
        else               r = {sign, biased[7:0], m[22:0]};
      end else begin
        r = {sign, 8'b0, m[22:0]};
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/core/fbsdp_if.sv
interface fbsdp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  weight_code;
  logic [31:0] activation_bits;
  logic [15:0] scale_bits;
  logic        last_element;

  modport source (output valid, weight_code, activation_bits, scale_bits, last_element,
                  input ready);
  modport sink (input valid, weight_code, activation_bits, scale_bits, last_element,
                output ready);
endinterface

interface fbsdp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] dot_product;

  modport source (output valid, dot_product, input ready);
  modport sink (input valid, dot_product, output ready);
endinterface

// File: rtl/core/fbsdp_front.sv
module fbsdp_front
  import fbsdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  fbsdp_in_if.sink   in_ch,
  output logic       push,
  output fe_item_t   push_item,
  input  logic       push_ready
);

  logic               a_valid;
  logic               a_sp;
  logic [47:0]        a_prod;
  logic signed [11:0] a_ep;
  logic               a_spec;
  logic [31:0]        a_spec_bits;
  logic [31:0]        a_act;
  logic               a_last;

  fnum_t       x;
  fnum_t       y;
  logic        sp;
  logic        spec;
  logic [31:0] spec_bits;
  logic        take;

  assign push         = a_valid;
  assign in_ch.ready  = !a_valid || push_ready;
  assign take         = in_ch.valid && in_ch.ready;

  always_comb begin
    x         = unpack(e4m3_bits(in_ch.weight_code));
    y         = unpack({in_ch.scale_bits, 16'b0});
    sp        = x.sign ^ y.sign;
    spec      = 1'b0;
    spec_bits = QNAN_BITS;
    if (x.kind == K_NAN || y.kind == K_NAN) begin
      spec = 1'b1;
    end else if (x.kind == K_INF || y.kind == K_INF) begin
      spec = 1'b1;
      if (!((x.kind == K_FIN && x.sig == '0) || (y.kind == K_FIN && y.sig == '0))) begin
        spec_bits = {sp, 8'hFF, 23'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take) begin
      a_valid <= 1'b1;
    end else if (push_ready) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_sp        <= sp;
      a_prod      <= x.sig * y.sig;
      a_ep        <= x.exp + y.exp;
      a_spec      <= spec;
      a_spec_bits <= spec_bits;
      a_act       <= in_ch.activation_bits;
      a_last      <= in_ch.last_element;
    end
  end

  always_comb begin
    push_item.ws   = a_spec ? a_spec_bits : round_pack(a_sp, {16'b0, a_prod}, a_ep);
    push_item.act  = a_act;
    push_item.last = a_last;
  end

endmodule

// File: rtl/core/fbsdp_queue.sv
module fbsdp_queue
  import fbsdp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  fe_item_t push_item,
  output logic     push_ready,
  input  logic     pop,
  output logic     pop_valid,
  output fe_item_t pop_item
);

  fe_item_t            mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_item;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (QPTR_W)'(wr_ptr - rd_ptr) == count[QPTR_W-1:0])
    else $error("queue pointers disagree with count");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance on transfer");
`endif

endmodule

// File: rtl/core/fbsdp_back.sv
module fbsdp_back
  import fbsdp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  input  fe_item_t  pop_item,
  output logic      pop,
  fbsdp_out_if.source out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]        state;
  logic              reducing;
  logic              row_last;
  logic [LIDX_W-1:0] idx;
  logic [LIDX_W-1:0] jdx;
  logic [31:0]       lane [LANES];
  logic [31:0]       sum;
  logic [31:0]       op_a;
  logic [31:0]       op_b;
  logic [31:0]       op_c;
  logic              out_valid;
  logic [31:0]       out_data;

  // multiply stage
  logic               m_sp;
  logic [47:0]        m_p;
  logic signed [11:0] m_ep;
  logic               m_zsign;
  logic [23:0]        m_zsig;
  logic signed [11:0] m_zexp;
  logic [31:0]        m_c;
  logic               m_spec;
  logic [31:0]        m_spec_bits;

  // add stage
  logic               a_direct;
  logic [31:0]        a_bits;
  logic [63:0]        a_r;
  logic signed [11:0] a_eb;
  logic               a_rs;

  fnum_t       x;
  fnum_t       y;
  fnum_t       z;
  logic        sp;
  logic        spec;
  logic [31:0] spec_bits;

  logic [5:0]         kp;
  logic [5:0]         kz;
  logic [63:0]        pn;
  logic [63:0]        zn;
  logic signed [11:0] epn;
  logic signed [11:0] ecn;
  logic [63:0]        bg;
  logic [63:0]        sm;
  logic [63:0]        sm_sh;
  logic signed [11:0] eb;
  logic signed [11:0] d;
  logic               sbg;
  logic               ssm;
  logic               n_direct;
  logic [31:0]        n_bits;
  logic [63:0]        n_r;
  logic signed [11:0] n_eb;
  logic               n_rs;
  logic [31:0]        res;

  assign out_ch.valid       = out_valid;
  assign out_ch.dot_product = out_data;
  assign pop                = (state == S_IDLE) && pop_valid;

  // special operands of a*b+c
  always_comb begin
    x         = unpack(op_a);
    y         = unpack(op_b);
    z         = unpack(op_c);
    sp        = x.sign ^ y.sign;
    spec      = 1'b0;
    spec_bits = QNAN_BITS;
    if (x.kind == K_NAN || y.kind == K_NAN || z.kind == K_NAN) begin
      spec = 1'b1;
    end else if (x.kind == K_INF || y.kind == K_INF) begin
      spec = 1'b1;
      if (!((x.kind == K_FIN && x.sig == '0) || (y.kind == K_FIN && y.sig == '0)) &&
          !(z.kind == K_INF && z.sign != sp)) begin
        spec_bits = {sp, 8'hFF, 23'b0};
      end
    end else if (z.kind == K_INF) begin
      spec      = 1'b1;
      spec_bits = op_c;
    end
  end

  // align and add
  always_comb begin
    kp    = msb64({16'b0, m_p});
    kz    = msb64({40'b0, m_zsig});
    pn    = {16'b0, m_p} << (7'd61 - {1'b0, kp});
    zn    = {40'b0, m_zsig} << (7'd61 - {1'b0, kz});
    epn   = m_ep - 12'(7'd61 - {1'b0, kp});
    ecn   = m_zexp - 12'(7'd61 - {1'b0, kz});
    if (epn >= ecn) begin
      bg = pn; sm = zn; eb = epn; sbg = m_sp; ssm = m_zsign; d = epn - ecn;
    end else begin
      bg = zn; sm = pn; eb = ecn; sbg = m_zsign; ssm = m_sp; d = ecn - epn;
    end
    if (d >= 12'sd64) begin
      sm_sh = {63'b0, |sm};
    end else if (d > 12'sd0) begin
      sm_sh = (sm >> d[5:0]) | {63'b0, |(sm & ((64'd1 << d[5:0]) - 64'd1))};
    end else begin
      sm_sh = sm;
    end
    n_direct = 1'b0;
    n_bits   = '0;
    n_eb     = eb;
    if (sbg == ssm) begin
      n_r = bg + sm_sh; n_rs = sbg;
    end else if (bg >= sm_sh) begin
      n_r = bg - sm_sh; n_rs = sbg;
    end else begin
      n_r = sm_sh - bg; n_rs = ssm;
    end
    if (m_spec) begin
      n_direct = 1'b1;
      n_bits   = m_spec_bits;
    end else if (m_p == '0) begin
      n_direct = 1'b1;
      n_bits   = (m_zsig != '0) ? m_c : {m_sp && m_zsign, 31'b0};
    end else if (m_zsig == '0) begin
      n_r  = {16'b0, m_p};
      n_eb = m_ep;
      n_rs = m_sp;
    end else if (n_r == '0) begin
      n_direct = 1'b1;
    end
  end

  assign res = a_direct ? a_bits : round_pack(a_rs, a_r, a_eb);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      reducing  <= 1'b0;
      row_last  <= 1'b0;
      idx       <= '0;
      jdx       <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < LANES; i++) lane[i] <= '0;
    end else begin
      if (out_valid && out_ch.ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop_valid) begin
            op_a     <= pop_item.ws;
            op_b     <= pop_item.act;
            op_c     <= lane[idx];
            row_last <= pop_item.last;
            state    <= S_MUL;
          end
        end
        S_MUL:  state <= S_ADD;
        S_ADD:  state <= S_RND;
        S_RND: begin
          if (!reducing) begin
            lane[idx] <= res;
            idx       <= (idx == LIDX_W'(LANES - 1)) ? '0 : idx + 1'b1;
            if (row_last) begin
              reducing <= 1'b1;
              jdx      <= '0;
              sum      <= '0;
              state    <= S_LOAD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            sum <= res;
            if (jdx == LIDX_W'(LANES - 1)) begin
              state <= S_OUT;
            end else begin
              jdx   <= jdx + 1'b1;
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          op_a  <= ONE_BITS;
          op_b  <= lane[jdx];
          op_c  <= sum;
          state <= S_MUL;
        end
        S_OUT: begin
          // hold the row sum until the output register frees up
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_data  <= sum;
            reducing  <= 1'b0;
            idx       <= '0;
            for (int i = 0; i < LANES; i++) lane[i] <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      m_sp        <= sp;
      m_p         <= x.sig * y.sig;
      m_ep        <= x.exp + y.exp;
      m_zsign     <= z.sign;
      m_zsig      <= z.sig;
      m_zexp      <= z.exp;
      m_c         <= op_c;
      m_spec      <= spec;
      m_spec_bits <= spec_bits;
    end
    if (state == S_ADD) begin
      a_direct <= n_direct;
      a_bits   <= n_bits;
      a_r      <= n_r;
      a_eb     <= n_eb;
      a_rs     <= n_rs;
    end
  end

`ifndef ASSERT_OFF
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == S_IDLE && !reducing)
    else $error("queue popped while busy");
  a_row_cleared: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && (!out_valid || out_ch.ready) |=> idx == '0 && out_valid)
    else $error("row not cleared after result");
  a_reduce_start: assert property (@(posedge clk) disable iff (rst)
    state == S_RND && !reducing && row_last |=> reducing && jdx == '0 && sum == '0)
    else $error("reduction did not start from zero");
`endif

endmodule

// File: rtl/core/fp8_block_scaled_dot_product_top.sv
// FP8 e4m3 block-scaled dot product, one matrix row per stream of items.
// in_ch: one element per transfer: e4m3 weight, FP32 activation, BF16 block
//   scale, and last_element marking the final column of the row.
// out_ch: one FP32 dot product per row, sent after the last element.
// The front stage registers the element, rounds weight*scale to FP32 and
// pushes it into a 4-entry queue from that register; the back stage
// pulls from it and runs one fused multiply-add unit in three steps per operation.
// Elements are paced by the shared FMA sequencer in the back stage, which pops
// only when idle; the front accepts one element per cycle until the queue fills.
// Row end: after the last element's FMA, the 8 lanes are summed in order with
// the same unit, each lane passing through the LOAD, MUL, ADD and RND states,
// and the sum is then placed in the output register from the S_OUT state.
// Reset clears all lane sums to +0, the lane index and the queue.
// When the receiver stalls, the result waits in the output register; the
// back stage keeps accumulating the next row and holds only when a second
// result is ready.
module fp8_block_scaled_dot_product_top
  import fbsdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  fbsdp_in_if.sink    in_ch,
  fbsdp_out_if.source out_ch
);

  logic     push;
  logic     push_ready;
  fe_item_t push_item;
  logic     pop;
  logic     pop_valid;
  fe_item_t pop_item;

  fbsdp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  fbsdp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  fbsdp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
